// ===== src/ray_march_circle_occluder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray march block
// Each macro wraps one concurrent assertion clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_MARCH_CIRCLE_OCCLUDER_MACROS_SVH
`define RAY_MARCH_CIRCLE_OCCLUDER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RMCO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RMCO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rmco_pkg.sv =====
// ----------------------------------------------------------------------------
// rmco_pkg
// Widths, screen limits, pipeline word types and the direction table.
// ----------------------------------------------------------------------------
package rmco_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = 30;
	localparam int DIR_W      = 18;
	localparam int PX_W       = 11;
	localparam int PY_W       = 10;
	localparam int CX_W       = 11;
	localparam int CY_W       = 10;
	localparam int R_W        = 10;
	localparam int ANG_W      = 5;
	localparam int NUM_RAYS   = 20;
	localparam int SCREEN_W   = 1600;
	localparam int SCREEN_H   = 800;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Offset magnitude inside the bounding box of the circle, split into a
	// whole pixel part and a fraction part for the squaring.
	localparam int DH_W = R_W;
	localparam int DL_W = FRAC_BITS;
	localparam int D_W  = DH_W + DL_W;
	localparam int SQ_W = 2 * D_W + 1;
	localparam int RSQ_W = 2 * R_W;

	localparam logic [POS_W-1:0] X_LIMIT = POS_W'(SCREEN_W * (2 ** FRAC_BITS));
	localparam logic [POS_W-1:0] Y_LIMIT = POS_W'(SCREEN_H * (2 ** FRAC_BITS));

	localparam logic [ANG_W-1:0] NUM_RAYS_V = ANG_W'(NUM_RAYS);

	localparam logic [CX_W-1:0]  CX_RESET  = CX_W'(1200);
	localparam logic [CY_W-1:0]  CY_RESET  = CY_W'(500);
	localparam logic [R_W-1:0]   R_RESET   = R_W'(160);
	localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(160 * 160);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_RADIUS   = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_type_t;

	typedef logic signed [DIR_W-1:0] dir_t;

	typedef struct packed {
		dir_t cos_v;
		dir_t sin_v;
	} dir_vec_t;

	// Position after the step (or the start position for a start word), two's complement Q13.16.
	typedef struct packed {
		logic             valid;
		logic             step;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} s1_t;

	typedef struct packed {
		logic            valid;
		logic            step;
		logic            off;
		logic            in_box;
		logic [D_W-1:0]  dx;
		logic [D_W-1:0]  dy;
		logic [PX_W-1:0] px;
		logic [PY_W-1:0] py;
	} s2_t;

	typedef struct packed {
		logic                   valid;
		logic                   step;
		logic                   off;
		logic                   in_box;
		logic [2*DH_W-1:0]      hh_x;
		logic [2*DH_W-1:0]      hh_y;
		logic [DH_W+DL_W-1:0]   hl_x;
		logic [DH_W+DL_W-1:0]   hl_y;
		logic [2*DL_W-1:0]      ll_x;
		logic [2*DL_W-1:0]      ll_y;
		logic [PX_W-1:0]        px;
		logic [PY_W-1:0]        py;
	} s3_t;

	// Unit vector of direction i, angle 2*pi*i/NUM_RAYS, Q1.16 rounded.
	function automatic dir_vec_t dir_lookup(input logic [ANG_W-1:0] idx);
		dir_vec_t v;
		case (idx)
			5'd0:  begin v.cos_v =  18'sd65536; v.sin_v =  18'sd0;     end
			5'd1:  begin v.cos_v =  18'sd62328; v.sin_v =  18'sd20252; end
			5'd2:  begin v.cos_v =  18'sd53020; v.sin_v =  18'sd38521; end
			5'd3:  begin v.cos_v =  18'sd38521; v.sin_v =  18'sd53020; end
			5'd4:  begin v.cos_v =  18'sd20252; v.sin_v =  18'sd62328; end
			5'd5:  begin v.cos_v =  18'sd0;     v.sin_v =  18'sd65536; end
			5'd6:  begin v.cos_v = -18'sd20252; v.sin_v =  18'sd62328; end
			5'd7:  begin v.cos_v = -18'sd38521; v.sin_v =  18'sd53020; end
			5'd8:  begin v.cos_v = -18'sd53020; v.sin_v =  18'sd38521; end
			5'd9:  begin v.cos_v = -18'sd62328; v.sin_v =  18'sd20252; end
			5'd10: begin v.cos_v = -18'sd65536; v.sin_v =  18'sd0;     end
			5'd11: begin v.cos_v = -18'sd62328; v.sin_v = -18'sd20252; end
			5'd12: begin v.cos_v = -18'sd53020; v.sin_v = -18'sd38521; end
			5'd13: begin v.cos_v = -18'sd38521; v.sin_v = -18'sd53020; end
			5'd14: begin v.cos_v = -18'sd20252; v.sin_v = -18'sd62328; end
			5'd15: begin v.cos_v =  18'sd0;     v.sin_v = -18'sd65536; end
			5'd16: begin v.cos_v =  18'sd20252; v.sin_v = -18'sd62328; end
			5'd17: begin v.cos_v =  18'sd38521; v.sin_v = -18'sd53020; end
			5'd18: begin v.cos_v =  18'sd53020; v.sin_v = -18'sd38521; end
			5'd19: begin v.cos_v =  18'sd62328; v.sin_v = -18'sd20252; end
			default: begin v.cos_v = 18'sd0; v.sin_v = 18'sd0; end
		endcase
		return v;
	endfunction

endpackage

// ===== src/ray_march_circle_occluder.sv =====
// ----------------------------------------------------------------------------
// ray_march_circle_occluder: unit step ray march against one circle
// A step word passes four registers in order (march, geometry, square, result);
// the first loads at the accepting edge.
// Throughput: one word per cycle while rsp_stall is low; each stage holds one word
// and advances whenever the next stage can take it.
// Reset clears the ray and the pipeline; circle registers return to 1200/500/160.
// ----------------------------------------------------------------------------
`include "ray_march_circle_occluder_macros.svh"

module ray_march_circle_occluder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rmco_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rmco_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              req_type,
	input  logic [rmco_pkg::PX_W-1:0]         start_x,
	input  logic [rmco_pkg::PY_W-1:0]         start_y,
	input  logic [rmco_pkg::ANG_W-1:0]        angle_index,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [rmco_pkg::PX_W-1:0]         pixel_x,
	output logic [rmco_pkg::PY_W-1:0]         pixel_y,
	output logic                              hit_occluder,
	output logic                              off_screen,
	output logic                              last
);

	localparam int SQ = rmco_pkg::SQ_W;
	localparam int FB = rmco_pkg::FRAC_BITS;

	logic [rmco_pkg::CX_W-1:0]  cx_q;
	logic [rmco_pkg::CY_W-1:0]  cy_q;
	logic [rmco_pkg::R_W-1:0]   r_q;
	logic [rmco_pkg::RSQ_W-1:0] rsq_q;
	logic                       act_q;

	logic                       valid_s4;
	logic [rmco_pkg::PX_W-1:0]  px_s4;
	logic [rmco_pkg::PY_W-1:0]  py_s4;
	logic                       hit_s4;
	logic                       off_s4;

	rmco_pkg::s1_t s1;
	rmco_pkg::s2_t s2;
	rmco_pkg::s3_t s3;
	logic          take2;
	logic          take3;
	logic          load4;

	logic [SQ-1:0] dist_sq;
	logic [SQ-1:0] lim_sq;
	logic          hit_c;
	logic          last_c;

	// Circle registers; the squared radius is kept alongside for the compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= rmco_pkg::CX_RESET;
			cy_q  <= rmco_pkg::CY_RESET;
			r_q   <= rmco_pkg::R_RESET;
			rsq_q <= rmco_pkg::RSQ_RESET;
		end else if (cfg_we) begin
			unique case (rmco_pkg::cfg_idx_t'(cfg_index))
				rmco_pkg::CFG_CENTER_X: cx_q <= cfg_data[rmco_pkg::CX_W-1:0];
				rmco_pkg::CFG_CENTER_Y: cy_q <= cfg_data[rmco_pkg::CY_W-1:0];
				rmco_pkg::CFG_RADIUS: begin
					r_q   <= cfg_data[rmco_pkg::R_W-1:0];
					rsq_q <= cfg_data[rmco_pkg::R_W-1:0] * cfg_data[rmco_pkg::R_W-1:0];
				end
				default: ;
			endcase
		end
	end

	rmco_march u_march (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.angle_index (angle_index),
		.take_next   (take2),
		.s1          (s1)
	);

	rmco_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.take_next (take3),
		.center_x  (cx_q),
		.center_y  (cy_q),
		.radius    (r_q),
		.take      (take2),
		.s2        (s2)
	);

	rmco_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2        (s2),
		.take_next (load4),
		.take      (take3),
		.s3        (s3)
	);

	assign load4 = !valid_s4 || !rsp_stall;

	always_comb begin
		dist_sq = ((SQ'(s3.hh_x) + SQ'(s3.hh_y)) << (2 * FB)) +
			((SQ'(s3.hl_x) + SQ'(s3.hl_y)) << (FB + 1)) +
			SQ'(s3.ll_x) + SQ'(s3.ll_y);
		lim_sq = SQ'(rsq_q) << (2 * FB);
		hit_c  = s3.in_box && (dist_sq < lim_sq);
		last_c = hit_c || s3.off;
	end

	// The ray's live flag is kept at the result stage, so steps that follow
	// the end of a ray are dropped here in word order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (load4) begin
			valid_s4 <= s3.valid && s3.step && act_q;
			if (s3.valid) begin
				if (!s3.step) begin
					act_q <= 1'b1;
				end else if (act_q && last_c) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load4 && s3.valid) begin
			px_s4  <= s3.px;
			py_s4  <= s3.py;
			hit_s4 <= hit_c;
			off_s4 <= s3.off;
		end
	end

	assign rsp_valid    = valid_s4;
	assign pixel_x      = px_s4;
	assign pixel_y      = py_s4;
	assign hit_occluder = hit_s4;
	assign off_screen   = off_s4;
	assign last         = hit_s4 || off_s4;

	`RMCO_ASSERT_NOW(a_last_ends_ray, rsp_valid && last, !act_q, "ray still live after its last word")
	`RMCO_ASSERT_NOW(a_on_screen_pixel, rsp_valid && !off_screen, (pixel_x <= rmco_pkg::PX_W'(rmco_pkg::SCREEN_W)) && (pixel_y <= rmco_pkg::PY_W'(rmco_pkg::SCREEN_H)), "on-screen word has pixel beyond screen")
	`RMCO_ASSERT_NEXT(a_start_enters, req_valid && !req_stall && (req_type == rmco_pkg::REQ_START), s1.valid && !s1.step, "accepted start word missing from first stage")

endmodule

// ===== src/rmco_march.sv =====
// ----------------------------------------------------------------------------
// rmco_march
// Input stage: holds the ray position and direction, loads both on an accepted
// start word and moves the position one unit step for every accepted step word.
// ----------------------------------------------------------------------------
module rmco_march (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           req_type,
	input  logic [rmco_pkg::PX_W-1:0]      start_x,
	input  logic [rmco_pkg::PY_W-1:0]      start_y,
	input  logic [rmco_pkg::ANG_W-1:0]     angle_index,
	input  logic                           take_next,
	output rmco_pkg::s1_t                  s1
);

	logic [rmco_pkg::POS_W-1:0] pos_x_q;
	logic [rmco_pkg::POS_W-1:0] pos_y_q;
	logic [rmco_pkg::ANG_W-1:0] dir_idx_q;
	logic                       valid_s1;
	logic                       step_s1;
	logic [rmco_pkg::POS_W-1:0] pos_x_s1;
	logic [rmco_pkg::POS_W-1:0] pos_y_s1;

	logic                       take;
	logic                       accept;
	logic [rmco_pkg::ANG_W-1:0] ang_red;
	rmco_pkg::dir_vec_t         dir;
	logic [rmco_pkg::POS_W-1:0] next_x;
	logic [rmco_pkg::POS_W-1:0] next_y;

	assign take      = !valid_s1 || take_next;
	assign req_stall = !take;
	assign accept    = req_valid && take;

	always_comb begin
		// Direction numbers past the last ray wrap around once.
		ang_red = (angle_index >= rmco_pkg::NUM_RAYS_V) ?
			(angle_index - rmco_pkg::NUM_RAYS_V) : angle_index;
		dir = rmco_pkg::dir_lookup(dir_idx_q);
		if (req_type == rmco_pkg::REQ_STEP) begin
			next_x = pos_x_q + rmco_pkg::POS_W'(dir.cos_v);
			next_y = pos_y_q + rmco_pkg::POS_W'(dir.sin_v);
		end else begin
			next_x = rmco_pkg::POS_W'({start_x, {rmco_pkg::FRAC_BITS{1'b0}}});
			next_y = rmco_pkg::POS_W'({start_y, {rmco_pkg::FRAC_BITS{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_idx_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				pos_x_q <= next_x;
				pos_y_q <= next_y;
				if (req_type == rmco_pkg::REQ_START) begin
					dir_idx_q <= ang_red;
				end
			end
			if (take) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1  <= (req_type == rmco_pkg::REQ_STEP);
			pos_x_s1 <= next_x;
			pos_y_s1 <= next_y;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.step  = step_s1;
	assign s1.pos_x = pos_x_s1;
	assign s1.pos_y = pos_y_s1;

endmodule

// ===== src/rmco_geom.sv =====
// ----------------------------------------------------------------------------
// rmco_geom
// Screen bounds, pixel coordinates and offsets from the circle center.
// ----------------------------------------------------------------------------
module rmco_geom (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rmco_pkg::s1_t              s1,
	input  logic                       take_next,
	input  logic [rmco_pkg::CX_W-1:0]  center_x,
	input  logic [rmco_pkg::CY_W-1:0]  center_y,
	input  logic [rmco_pkg::R_W-1:0]   radius,
	output logic                       take,
	output rmco_pkg::s2_t              s2
);

	localparam int PW = rmco_pkg::POS_W;
	localparam int FB = rmco_pkg::FRAC_BITS;

	logic                       valid_s2;
	logic                       step_s2;
	logic                       off_s2;
	logic                       in_box_s2;
	logic [rmco_pkg::D_W-1:0]   dx_s2;
	logic [rmco_pkg::D_W-1:0]   dy_s2;
	logic [rmco_pkg::PX_W-1:0]  px_s2;
	logic [rmco_pkg::PY_W-1:0]  py_s2;

	logic [PW:0]                dx_w;
	logic [PW:0]                dy_w;
	logic [PW:0]                dx_abs;
	logic [PW:0]                dy_abs;
	logic [rmco_pkg::D_W-1:0]   lim;
	logic                       off_c;
	logic                       in_box_c;
	logic [rmco_pkg::PX_W-1:0]  px_c;
	logic [rmco_pkg::PY_W-1:0]  py_c;

	assign take = !valid_s2 || take_next;

	always_comb begin
		dx_w = {s1.pos_x[PW-1], s1.pos_x} - (PW+1)'({center_x, {FB{1'b0}}});
		dy_w = {s1.pos_y[PW-1], s1.pos_y} - (PW+1)'({center_y, {FB{1'b0}}});
		dx_abs = dx_w[PW] ? (~dx_w + 1'b1) : dx_w;
		dy_abs = dy_w[PW] ? (~dy_w + 1'b1) : dy_w;
		lim = {radius, {FB{1'b0}}};
		in_box_c = (dx_abs[PW-1:0] < PW'(lim)) && (dy_abs[PW-1:0] < PW'(lim));

		off_c = s1.pos_x[PW-1] || (s1.pos_x > rmco_pkg::X_LIMIT) ||
			s1.pos_y[PW-1] || (s1.pos_y > rmco_pkg::Y_LIMIT);

		// Negative positions read as zero, large ones saturate at the field maximum.
		if (s1.pos_x[PW-1]) begin
			px_c = '0;
		end else if (|s1.pos_x[PW-1:FB+rmco_pkg::PX_W]) begin
			px_c = '1;
		end else begin
			px_c = s1.pos_x[FB+rmco_pkg::PX_W-1:FB];
		end
		if (s1.pos_y[PW-1]) begin
			py_c = '0;
		end else if (|s1.pos_y[PW-1:FB+rmco_pkg::PY_W]) begin
			py_c = '1;
		end else begin
			py_c = s1.pos_y[FB+rmco_pkg::PY_W-1:FB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s1.valid) begin
			step_s2   <= s1.step;
			off_s2    <= off_c;
			in_box_s2 <= in_box_c;
			dx_s2     <= dx_abs[rmco_pkg::D_W-1:0];
			dy_s2     <= dy_abs[rmco_pkg::D_W-1:0];
			px_s2     <= px_c;
			py_s2     <= py_c;
		end
	end

	assign s2.valid  = valid_s2;
	assign s2.step   = step_s2;
	assign s2.off    = off_s2;
	assign s2.in_box = in_box_s2;
	assign s2.dx     = dx_s2;
	assign s2.dy     = dy_s2;
	assign s2.px     = px_s2;
	assign s2.py     = py_s2;

endmodule

// ===== src/rmco_square.sv =====
// ----------------------------------------------------------------------------
// rmco_square
// Partial products of the squared offsets, split at the pixel boundary.
// ----------------------------------------------------------------------------
module rmco_square (
	input  logic          clk,
	input  logic          arst_n,
	input  rmco_pkg::s2_t s2,
	input  logic          take_next,
	output logic          take,
	output rmco_pkg::s3_t s3
);

	localparam int DH = rmco_pkg::DH_W;
	localparam int DL = rmco_pkg::DL_W;

	logic                       valid_s3;
	logic                       step_s3;
	logic                       off_s3;
	logic                       in_box_s3;
	logic [2*DH-1:0]            hh_x_s3;
	logic [2*DH-1:0]            hh_y_s3;
	logic [DH+DL-1:0]           hl_x_s3;
	logic [DH+DL-1:0]           hl_y_s3;
	logic [2*DL-1:0]            ll_x_s3;
	logic [2*DL-1:0]            ll_y_s3;
	logic [rmco_pkg::PX_W-1:0]  px_s3;
	logic [rmco_pkg::PY_W-1:0]  py_s3;

	logic [DH-1:0] dh_x;
	logic [DH-1:0] dh_y;
	logic [DL-1:0] dl_x;
	logic [DL-1:0] dl_y;

	assign take = !valid_s3 || take_next;

	assign dh_x = s2.dx[DH+DL-1:DL];
	assign dl_x = s2.dx[DL-1:0];
	assign dh_y = s2.dy[DH+DL-1:DL];
	assign dl_y = s2.dy[DL-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s2.valid) begin
			step_s3   <= s2.step;
			off_s3    <= s2.off;
			in_box_s3 <= s2.in_box;
			hh_x_s3   <= dh_x * dh_x;
			hh_y_s3   <= dh_y * dh_y;
			hl_x_s3   <= dh_x * dl_x;
			hl_y_s3   <= dh_y * dl_y;
			ll_x_s3   <= dl_x * dl_x;
			ll_y_s3   <= dl_y * dl_y;
			px_s3     <= s2.px;
			py_s3     <= s2.py;
		end
	end

	assign s3.valid  = valid_s3;
	assign s3.step   = step_s3;
	assign s3.off    = off_s3;
	assign s3.in_box = in_box_s3;
	assign s3.hh_x   = hh_x_s3;
	assign s3.hh_y   = hh_y_s3;
	assign s3.hl_x   = hl_x_s3;
	assign s3.hl_y   = hl_y_s3;
	assign s3.ll_x   = ll_x_s3;
	assign s3.ll_y   = ll_y_s3;
	assign s3.px     = px_s3;
	assign s3.py     = py_s3;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the circle occluder ray march
// Walks a directed table, then random rays under several circle settings.
// Every step result is checked against a typed table value or a fixed point predictor of the march.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam logic REQ_START = rmco_pkg::REQ_START;
	localparam logic REQ_STEP  = rmco_pkg::REQ_STEP;
	localparam int   FRAC      = rmco_pkg::FRAC_BITS;
	localparam longint SCR_X_FIX = longint'(rmco_pkg::SCREEN_W) <<< FRAC;
	localparam longint SCR_Y_FIX = longint'(rmco_pkg::SCREEN_H) <<< FRAC;
	localparam longint Q30_ONE = 64'd1073741824;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ROW_COUNT    = 26;

	typedef struct packed {
		logic [rmco_pkg::PX_W-1:0] px;
		logic [rmco_pkg::PY_W-1:0] py;
		logic                      hit;
		logic                      off;
		logic                      fin;
	} step_result_t;

	typedef struct packed {
		logic                       kind;
		logic [rmco_pkg::PX_W-1:0]  sx;
		logic [rmco_pkg::PY_W-1:0]  sy;
		logic [rmco_pkg::ANG_W-1:0] ang;
		logic                       typed;
		step_result_t               res;
	} row_t;

	// Rows with typed results can be read straight off the geometry; the rest
	// go through the predictor. Reset circle is center (1200, 500), radius 160.
	localparam row_t DIRECTED [ROW_COUNT] = '{
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b0, '{11'd0,    10'd0,    1'b0, 1'b0, 1'b0}},
		'{REQ_START, 11'd0,    10'd0,    5'd0,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd1,    10'd0,    1'b0, 1'b0, 1'b0}},
		'{REQ_START, 11'd0,    10'd0,    5'd10, 1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd0,    10'd0,    1'b0, 1'b1, 1'b1}},
		'{REQ_STEP,  11'd2047, 10'd1023, 5'd31, 1'b0, '0},
		'{REQ_START, 11'd2047, 10'd1023, 5'd0,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd2047, 10'd1023, 1'b0, 1'b1, 1'b1}},
		'{REQ_START, 11'd1600, 10'd800,  5'd5,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd1600, 10'd801,  1'b0, 1'b1, 1'b1}},
		'{REQ_START, 11'd1600, 10'd800,  5'd15, 1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd1600, 10'd799,  1'b0, 1'b0, 1'b0}},
		'{REQ_START, 11'd100,  10'd100,  5'd25, 1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd100,  10'd101,  1'b0, 1'b0, 1'b0}},
		'{REQ_START, 11'd1039, 10'd500,  5'd0,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd1040, 10'd500,  1'b0, 1'b0, 1'b0}},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b1, '{11'd1041, 10'd500,  1'b1, 1'b0, 1'b1}},
		'{REQ_START, 11'd1200, 10'd500,  5'd31, 1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b0, '0},
		'{REQ_START, 11'd5,    10'd5,    5'd1,  1'b0, '0},
		'{REQ_START, 11'd30,   10'd20,   5'd7,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b0, '0},
		'{REQ_START, 11'd1800, 10'd900,  5'd3,  1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b0, '0},
		'{REQ_START, 11'd0,    10'd0,    5'd18, 1'b0, '0},
		'{REQ_STEP,  11'd0,    10'd0,    5'd0,  1'b0, '0}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [rmco_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rmco_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            req_valid;
	logic                            req_stall;
	logic                            req_type;
	logic [rmco_pkg::PX_W-1:0]       start_x;
	logic [rmco_pkg::PY_W-1:0]       start_y;
	logic [rmco_pkg::ANG_W-1:0]      angle_index;
	logic                            rsp_valid;
	logic                            rsp_stall;
	logic [rmco_pkg::PX_W-1:0]       pixel_x;
	logic [rmco_pkg::PY_W-1:0]       pixel_y;
	logic                            hit_occluder;
	logic                            off_screen;
	logic                            last;

	// Bench-side companions of the request word: a typed expectation, if any.
	logic                 word_typed;
	step_result_t         word_res;

	// Predictor state.
	longint                     heading_dx [rmco_pkg::NUM_RAYS];
	longint                     heading_dy [rmco_pkg::NUM_RAYS];
	longint                     pos_x;
	longint                     pos_y;
	int                         heading;
	bit                         ray_on;
	logic [rmco_pkg::CX_W-1:0]  occ_cx;
	logic [rmco_pkg::CY_W-1:0]  occ_cy;
	logic [rmco_pkg::R_W-1:0]   occ_r;

	step_result_t         pending_pixels [$];
	int                   live_words;
	int                   ray_starts;
	int                   checked_results;
	int                   hits_seen;
	int                   offs_seen;
	int                   fail_count;
	int                   cycle_count;
	bit                   quiet_tail;

	ray_march_circle_occluder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.start_x      (start_x),
		.start_y      (start_y),
		.angle_index  (angle_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.hit_occluder (hit_occluder),
		.off_screen   (off_screen),
		.last         (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Unit direction vectors, cos and sin from a short series per quarter
	// turn, rounded to nearest at 16 fraction bits.
	function automatic void build_heading_table();
		longint unsigned a, a2, ts, tc;
		longint s, c, cm, sm;
		int quarter, rem;
		for (int i = 0; i < rmco_pkg::NUM_RAYS; i++) begin
			quarter = (4 * i) / rmco_pkg::NUM_RAYS;
			rem = (4 * i) % rmco_pkg::NUM_RAYS;
			a = (Q30_HALF_PI * longint'(rem)) / rmco_pkg::NUM_RAYS;
			a2 = (a * a) >> 30;
			ts = a;
			tc = Q30_ONE;
			s = longint'(a);
			c = Q30_ONE;
			for (int k = 1; k <= 9; k++) begin
				ts = ((ts * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
				tc = ((tc * a2) >> 30) / longint'((2 * k - 1) * (2 * k));
				if (k % 2 == 1) begin
					s -= longint'(ts);
					c -= longint'(tc);
				end else begin
					s += longint'(ts);
					c += longint'(tc);
				end
			end
			if (c < 0) c = 0;
			if (c > Q30_ONE) c = Q30_ONE;
			if (s < 0) s = 0;
			if (s > Q30_ONE) s = Q30_ONE;
			cm = (c + (longint'(1) <<< 13)) >>> 14;
			sm = (s + (longint'(1) <<< 13)) >>> 14;
			case (quarter % 4)
				0: begin heading_dx[i] = cm;  heading_dy[i] = sm;  end
				1: begin heading_dx[i] = -sm; heading_dy[i] = cm;  end
				2: begin heading_dx[i] = -cm; heading_dy[i] = -sm; end
				default: begin heading_dx[i] = sm; heading_dy[i] = -cm; end
			endcase
		end
	endfunction

	function automatic longint clamp_pixel(input longint p, input longint maxv);
		longint t;
		if (p < 0) return 0;
		t = p >>> FRAC;
		return (t > maxv) ? maxv : t;
	endfunction

	function automatic step_result_t march_step();
		longint ax, ay, lim;
		longint unsigned d2;
		step_result_t r;
		pos_x += heading_dx[heading];
		pos_y += heading_dy[heading];
		r.off = (pos_x < 0) || (pos_x > SCR_X_FIX) || (pos_y < 0) || (pos_y > SCR_Y_FIX);
		ax = pos_x - (longint'(occ_cx) <<< FRAC);
		ay = pos_y - (longint'(occ_cy) <<< FRAC);
		if (ax < 0) ax = -ax;
		if (ay < 0) ay = -ay;
		lim = longint'(occ_r) <<< FRAC;
		r.hit = 1'b0;
		if (ax < lim && ay < lim) begin
			d2 = longint'(ax * ax) + longint'(ay * ay);
			r.hit = d2 < longint'(lim * lim);
		end
		r.fin = r.hit | r.off;
		r.px = rmco_pkg::PX_W'(clamp_pixel(pos_x, 2047));
		r.py = rmco_pkg::PY_W'(clamp_pixel(pos_y, 1023));
		if (r.fin) ray_on = 1'b0;
		return r;
	endfunction

	// Track register writes and accepted request words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					rmco_pkg::CFG_CENTER_X: occ_cx <= cfg_data[rmco_pkg::CX_W-1:0];
					rmco_pkg::CFG_CENTER_Y: occ_cy <= cfg_data[rmco_pkg::CY_W-1:0];
					rmco_pkg::CFG_RADIUS:   occ_r  <= cfg_data[rmco_pkg::R_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				if (req_type == REQ_START) begin
					pos_x = longint'(start_x) <<< FRAC;
					pos_y = longint'(start_y) <<< FRAC;
					heading = int'(angle_index) % rmco_pkg::NUM_RAYS;
					ray_on = 1'b1;
					live_words++;
					ray_starts++;
				end else if (ray_on) begin
					if (word_typed) begin
						void'(march_step());
						pending_pixels.push_back(word_res);
					end else begin
						pending_pixels.push_back(march_step());
					end
					live_words++;
				end
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		step_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("result word with no step pending: pixel (%0d, %0d)", pixel_x, pixel_y);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				checked_results++;
				if (hit_occluder) hits_seen++;
				if (off_screen) offs_seen++;
				if (pixel_x !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
					fail_count++;
				end
				if (pixel_y !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
					fail_count++;
				end
				if (hit_occluder !== want.hit) begin
					$error("hit_occluder: expected %0d, got %0d", want.hit, hit_occluder);
					fail_count++;
				end
				if (off_screen !== want.off) begin
					$error("off_screen: expected %0d, got %0d", want.off, off_screen);
					fail_count++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0d, got %0d", want.fin, last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_pixels.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side back-pressure in short random bursts.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_tail && (cycle_count % 900) >= 120 && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(input logic kind, input logic [rmco_pkg::PX_W-1:0] x,
			input logic [rmco_pkg::PY_W-1:0] y, input logic [rmco_pkg::ANG_W-1:0] ang,
			input logic typed, input step_result_t res);
		if (!quiet_tail && (cycle_count % 1000) >= 150 && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		start_x     <= x;
		start_y     <= y;
		angle_index <= ang;
		word_typed  <= typed;
		word_res    <= res;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Let the pipeline empty, including words that produce no result. The
	// first edge makes sure the last accepted step has been queued.
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input rmco_pkg::cfg_idx_t idx,
			input logic [rmco_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_circle(input int cx, input int cy, input int r);
		settle();
		write_reg(rmco_pkg::CFG_CENTER_X, rmco_pkg::CFG_DATA_W'(cx));
		write_reg(rmco_pkg::CFG_CENTER_Y, rmco_pkg::CFG_DATA_W'(cy));
		write_reg(rmco_pkg::CFG_RADIUS, rmco_pkg::CFG_DATA_W'(r));
		@(posedge clk);
	endtask

	function automatic int fit(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	// Rays with random origins, biased toward the circle and the screen
	// edges so that both kinds of ending show up often.
	task automatic run_rays(input int target);
		logic [rmco_pkg::PX_W-1:0] ox;
		logic [rmco_pkg::PY_W-1:0] oy;
		int pick, span, steps;
		while (live_words < target) begin
			pick = $urandom_range(0, 2);
			span = int'(occ_r) + 40;
			if (pick == 0) begin
				ox = rmco_pkg::PX_W'(fit(int'(occ_cx) + int'($urandom_range(0, 2 * span)) - span,
					2047));
				oy = rmco_pkg::PY_W'(fit(int'(occ_cy) + int'($urandom_range(0, 2 * span)) - span,
					1023));
			end else if (pick == 1) begin
				ox = $urandom_range(0, 1) ? rmco_pkg::PX_W'($urandom_range(0, 24))
					: rmco_pkg::PX_W'($urandom_range(1576, 1624));
				oy = $urandom_range(0, 1) ? rmco_pkg::PY_W'($urandom_range(0, 24))
					: rmco_pkg::PY_W'($urandom_range(776, 824));
			end else begin
				ox = rmco_pkg::PX_W'($urandom);
				oy = rmco_pkg::PY_W'($urandom);
			end
			send_word(REQ_START, ox, oy, rmco_pkg::ANG_W'($urandom), 1'b0, '0);
			steps = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 25);
			for (int n = 0; n < steps && ray_on; n++)
				send_word(REQ_STEP, rmco_pkg::PX_W'($urandom), rmco_pkg::PY_W'($urandom),
					rmco_pkg::ANG_W'($urandom), 1'b0, '0);
			// A stray step now and then, usually after the ray has ended.
			if ($urandom_range(0, 7) == 0)
				send_word(REQ_STEP, rmco_pkg::PX_W'($urandom), rmco_pkg::PY_W'($urandom),
					rmco_pkg::ANG_W'($urandom), 1'b0, '0);
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= rmco_pkg::CFG_CENTER_X;
		cfg_data    <= '0;
		req_valid   <= 1'b0;
		req_type    <= REQ_START;
		start_x     <= '0;
		start_y     <= '0;
		angle_index <= '0;
		word_typed  <= 1'b0;
		word_res    <= '0;
		cycle_count = 0;
		fail_count = 0;
		live_words = 0;
		ray_starts = 0;
		checked_results = 0;
		hits_seen = 0;
		offs_seen = 0;
		quiet_tail = 1'b0;
		pos_x = 0;
		pos_y = 0;
		heading = 0;
		ray_on = 1'b0;
		occ_cx = 11'd1200;
		occ_cy = 10'd500;
		occ_r = 10'd160;
		build_heading_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_word(DIRECTED[i].kind, DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].ang,
				DIRECTED[i].typed, DIRECTED[i].res);

		set_circle(0, 0, 1023);
		run_rays(600);
		set_circle(2047, 1023, 0);
		run_rays(1000);
		set_circle($urandom_range(0, 1600), $urandom_range(0, 800), $urandom_range(1, 400));
		run_rays(1500);
		set_circle($urandom_range(0, 2047), $urandom_range(0, 1023), $urandom_range(0, 1023));
		run_rays(1800);
		quiet_tail = 1'b1;
		run_rays(2100);
		settle();

		$display("Checked %0d step results over %0d live words and %0d ray starts.",
			checked_results, live_words, ray_starts);
		$display("Rays ended %0d times on the circle and %0d times off screen.",
			hits_seen, offs_seen);
		if (fail_count == 0 && pending_pixels.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/rmco_pkg.sv
src/rmco_march.sv
src/rmco_geom.sv
src/rmco_square.sv
src/ray_march_circle_occluder.sv
tb/sv/tb.sv
